// ----- rtl/salru_pkg.sv -----
`timescale 1ns / 1ps

package salru_pkg;

    // field widths
    localparam int FUNC_W     = 2;
    localparam int STAMP_W    = 32;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SET_CFG_W  = 3;
    localparam int WAYS_CFG_W = 4;
    localparam int BLK_CFG_W  = 6;

    // access kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

    // register reset values
    localparam logic [SET_CFG_W-1:0]  SET_BITS_RESET   = 3'd4;
    localparam logic [WAYS_CFG_W-1:0] WAYS_RESET       = 4'd1;
    localparam logic [BLK_CFG_W-1:0]  BLOCK_BITS_RESET = 6'd4;

    // one result word
    typedef struct packed {
        logic               hit;
        logic               miss;
        logic               eviction;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] eviction_total;
        logic               last_of_item;
    } result_t;

endpackage

// ----- rtl/salru_if.sv -----
`timescale 1ns / 1ps

// request channel
interface salru_in_if #(
    parameter int ADDR_BITS = 64
);
    logic                          valid;
    logic                          ready;
    logic [salru_pkg::FUNC_W-1:0]  func;
    logic [ADDR_BITS-1:0]          address;

    modport source (output valid, output func, output address, input ready);
    modport sink   (input valid, input func, input address, output ready);
endinterface

// result channel
interface salru_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          miss;
    logic                          eviction;
    logic [salru_pkg::COUNT_W-1:0] hit_total;
    logic [salru_pkg::COUNT_W-1:0] miss_total;
    logic [salru_pkg::COUNT_W-1:0] eviction_total;
    logic                          last_of_item;

    modport source (output valid, output hit, output miss, output eviction,
                    output hit_total, output miss_total, output eviction_total,
                    output last_of_item, input ready);
    modport sink   (input valid, input hit, input miss, input eviction,
                    input hit_total, input miss_total, input eviction_total,
                    input last_of_item, output ready);
endinterface

// ----- rtl/set_assoc_lru_cache_tag_sim_unit.sv -----
`timescale 1ns / 1ps
// Result word is registered after a request is accepted: one set row read, then compare
// and write back, held while the output register is full. A load or store gives one word
// per request, a modify two (its second word is a hit that needs no set access). The next
// request is taken the cycle after the last word of the previous one enters the output
// register. Reset is asynchronous; afterwards a clearing pass zeroes every set row while
// requests are held off (configuration writes still taken).
module set_assoc_lru_cache_tag_sim_unit #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0] cfg_data,
    salru_in_if.sink                         cmd,
    salru_out_if.source                      res
);
    import salru_pkg::*;

    localparam int ROWS     = 1 << MAX_SET_BITS;
    localparam int ROW_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LEAVES   = 1 << $clog2(MAX_WAYS);
    localparam int NODES    = 2 * LEAVES - 1;
    localparam int SB_W     = BLK_CFG_W + 1;
    localparam int SEFF_W   = $clog2(MAX_SET_BITS + 1) > 0 ? $clog2(MAX_SET_BITS + 1) : 1;
    localparam int WEFF_W   = WAYS_CFG_W + 1;

    typedef struct packed {
        logic [MAX_WAYS-1:0]                valid;
        logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
        logic [MAX_WAYS-1:0][STAMP_W-1:0]   stamp;
    } row_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_SECOND = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [ROW_W-1:0]     clr_idx_reg;
    logic [SET_CFG_W-1:0] set_bits_reg;
    logic [WAYS_CFG_W-1:0] ways_reg;
    logic [BLK_CFG_W-1:0] block_bits_reg;
    logic [STAMP_W-1:0]   access_cnt_reg;
    logic [COUNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]   miss_cnt_reg, miss_cnt_next;
    logic [COUNT_W-1:0]   evict_cnt_reg, evict_cnt_next;
    logic [FUNC_W-1:0]    func_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [ROW_W-1:0]     set_reg;
    row_t                 rd_row_reg;
    result_t              res_reg, res_next;
    logic                 res_valid_reg;

    row_t                 mem [ROWS];

    logic                 accept;
    logic                 out_free;
    logic                 res_load;

    // address split
    logic [SEFF_W-1:0]    s_eff;
    logic [SB_W-1:0]      sb;
    logic [ADDR_BITS-1:0] shifted;
    logic [ROW_W-1:0]     set_mask;
    logic [ROW_W-1:0]     set_in;
    logic [ADDR_BITS-1:0] tag_in;

    // lookup
    logic [WEFF_W-1:0]    ways_eff;
    logic [MAX_WAYS-1:0]  in_use, match, empty;
    logic                 hit_any, empty_any;
    logic [WAY_W-1:0]     hit_way, empty_way, fill_way;
    logic                 node_ok [NODES];
    logic [STAMP_W-1:0]   node_st [NODES];
    logic [WAY_W-1:0]     node_ix [NODES];
    row_t                 row_next;
    logic                 do_write;
    logic [ROW_W-1:0]     wr_addr;
    row_t                 wr_row;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_free  = !res_valid_reg || res.ready;

    // set index and tag of the incoming request
    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
            s_eff = SEFF_W'(MAX_SET_BITS);
        else
            s_eff = SEFF_W'(set_bits_reg);
        sb       = SB_W'(block_bits_reg) + SB_W'(s_eff);
        shifted  = cmd.address >> block_bits_reg;
        set_mask = ~({ROW_W{1'b1}} << s_eff);
        set_in   = shifted[ROW_W-1:0] & set_mask;
        tag_in   = cmd.address >> sb;
    end

    // way search on the set row
    always_comb
    begin
        if (ways_reg == '0)
            ways_eff = WEFF_W'(1);
        else if ({1'b0, ways_reg} > WEFF_W'(MAX_WAYS))
            ways_eff = WEFF_W'(MAX_WAYS);
        else
            ways_eff = {1'b0, ways_reg};

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w] = WEFF_W'(w) < ways_eff;
            match[w]  = in_use[w] && rd_row_reg.valid[w] && (rd_row_reg.tag[w] == tag_reg);
            empty[w]  = in_use[w] && !rd_row_reg.valid[w];
        end

        hit_any   = |match;
        empty_any = |empty;
        hit_way   = '0;
        empty_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
                hit_way = WAY_W'(w);
            if (empty[w])
                empty_way = WAY_W'(w);
        end
    end

    // oldest valid way, lower way wins a tie
    always_comb
    begin
        for (int n = 0; n < NODES; n++)
        begin
            node_ok[n] = 1'b0;
            node_st[n] = '0;
            node_ix[n] = '0;
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            node_ok[LEAVES-1+w] = in_use[w] && rd_row_reg.valid[w];
            node_st[LEAVES-1+w] = rd_row_reg.stamp[w];
            node_ix[LEAVES-1+w] = WAY_W'(w);
        end
        for (int n = LEAVES - 2; n >= 0; n--)
        begin
            if (node_ok[2*n+1] && (!node_ok[2*n+2] || node_st[2*n+1] <= node_st[2*n+2]))
            begin
                node_ok[n] = node_ok[2*n+1];
                node_st[n] = node_st[2*n+1];
                node_ix[n] = node_ix[2*n+1];
            end
            else
            begin
                node_ok[n] = node_ok[2*n+2];
                node_st[n] = node_st[2*n+2];
                node_ix[n] = node_ix[2*n+2];
            end
        end
    end

    // row update, result word and next state
    always_comb
    begin
        row_next       = rd_row_reg;
        fill_way       = empty_any ? empty_way : node_ix[0];
        res_next       = res_reg;
        res_load       = 1'b0;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        state_next     = state_reg;

        if (hit_any)
        begin
            row_next.stamp[hit_way] = access_cnt_reg;
        end
        else
        begin
            row_next.valid[fill_way] = 1'b1;
            row_next.tag[fill_way]   = tag_reg;
            row_next.stamp[fill_way] = access_cnt_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == ROW_W'(ROWS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (hit_any)
                        hit_cnt_next = hit_cnt_reg + COUNT_W'(1);
                    else
                        miss_cnt_next = miss_cnt_reg + COUNT_W'(1);
                    if (!hit_any && !empty_any)
                        evict_cnt_next = evict_cnt_reg + COUNT_W'(1);
                    res_next.hit            = hit_any;
                    res_next.miss           = !hit_any;
                    res_next.eviction       = !hit_any && !empty_any;
                    res_next.hit_total      = hit_cnt_next;
                    res_next.miss_total     = miss_cnt_next;
                    res_next.eviction_total = evict_cnt_next;
                    res_next.last_of_item   = (func_reg != FUNC_MODIFY);
                    state_next = (func_reg == FUNC_MODIFY) ? ST_SECOND : ST_IDLE;
                end
            end
            ST_SECOND:
            begin
                // second access of a modify finds the line just touched
                if (out_free)
                begin
                    res_load                = 1'b1;
                    hit_cnt_next            = hit_cnt_reg + COUNT_W'(1);
                    res_next.hit            = 1'b1;
                    res_next.miss           = 1'b0;
                    res_next.eviction       = 1'b0;
                    res_next.hit_total      = hit_cnt_next;
                    res_next.miss_total     = miss_cnt_reg;
                    res_next.eviction_total = evict_cnt_reg;
                    res_next.last_of_item   = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // memory write port select
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            do_write = 1'b1;
            wr_addr  = clr_idx_reg;
            wr_row   = '0;
        end
        else
        begin
            do_write = (state_reg == ST_LOOKUP) && out_free;
            wr_addr  = set_reg;
            wr_row   = row_next;
        end
    end

    // set memory, one row per set
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_addr] <= wr_row;
        if (accept)
            rd_row_reg <= mem[set_in];
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= cmd.func;
            tag_reg  <= tag_in;
            set_reg  <= set_in;
        end
        if (res_load)
            res_reg <= res_next;
    end

    // control, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            set_bits_reg   <= SET_BITS_RESET;
            ways_reg       <= WAYS_RESET;
            block_bits_reg <= BLOCK_BITS_RESET;
            access_cnt_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
            if (state_reg == ST_CLEAR)
                clr_idx_reg <= clr_idx_reg + ROW_W'(1);
            if (accept)
                access_cnt_reg <= access_cnt_reg + STAMP_W'(1);
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SET_INDEX_BITS:    set_bits_reg   <= cfg_data[SET_CFG_W-1:0];
                    CFG_WAYS_IN_USE:       ways_reg       <= cfg_data[WAYS_CFG_W-1:0];
                    CFG_BLOCK_OFFSET_BITS: block_bits_reg <= cfg_data[BLK_CFG_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    // result channel
    assign res.valid          = res_valid_reg;
    assign res.hit            = res_reg.hit;
    assign res.miss           = res_reg.miss;
    assign res.eviction       = res_reg.eviction;
    assign res.hit_total      = res_reg.hit_total;
    assign res.miss_total     = res_reg.miss_total;
    assign res.eviction_total = res_reg.eviction_total;
    assign res.last_of_item   = res_reg.last_of_item;

endmodule
